[rtl/bbe_pkg.sv]
`default_nettype none
package bbe_pkg;

	localparam int PIX_W   = 24;
	localparam int CH_W    = 8;
	localparam int SUM_W   = 12;
	localparam int CNT_W   = 4;
	localparam int RECIP_W = 20;
	localparam int PROD_W  = SUM_W + 1 + RECIP_W;

	localparam int  CFG_ADDR_W = 1;
	localparam int  CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic               ld_pix;
		logic               in_frame;
		logic               shift;
		logic               col0;
		logic [8:0]         mask;
		logic [CNT_W-1:0]   count;
		logic [RECIP_W-1:0] recip;
		logic               load;
		logic               last;
	} bbe_cmd_t;

	typedef struct packed {
		logic out_busy;
	} bbe_stat_t;

	// cells of the 3x3 view that fall inside the frame, index = column*3 + row
	function automatic logic [8:0] cell_mask(input logic [1:0] clo, input logic [1:0] rlo,
			input logic [1:0] rhi);
		logic [8:0] m;
		m = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				m[c*3+r] = (2'(c) >= clo) && (2'(r) >= rlo) && (2'(r) <= rhi);
			end
		end
		return m;
	endfunction

	// ceil(2^20 / (2*count))
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] r;
		case (count)
			4'd1:    r = 20'd524288;
			4'd2:    r = 20'd262144;
			4'd3:    r = 20'd174763;
			4'd4:    r = 20'd131072;
			4'd6:    r = 20'd87382;
			4'd9:    r = 20'd58255;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/bbe_ram.sv]
`default_nettype none
module bbe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/bbe_ctrl.sv]
`default_nettype none
module bbe_ctrl import bbe_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output      logic                    s_tready,
	input  wire logic                    cfg_wr,
	input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire bbe_stat_t               stat,
	output      bbe_cmd_t                cmd,
	output      logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output      logic                    wr_en,
	output      logic [$clog2(MAX_WIDTH)-1:0] wr_addr
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;

	logic [1:0]  state_q;
	logic [10:0] width_q;
	logic [15:0] height_q;

	logic [AW-1:0] col_q, ncol_q, hold_q;
	logic [WW-1:0] pre_q;
	logic          active_q;
	logic [15:0]   nrow_q;
	logic [16:0]   krow_q;

	logic               col0_q, prod_q, last_q;
	logic [8:0]         mask_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RECIP_W-1:0] recip_q;

	logic [WW-1:0] weff, w_m1;
	logic [15:0]   heff, h_m1;
	logic          accept, col_wrap, last;
	logic [1:0]    clo, rlo, rhi;
	logic [CNT_W-1:0] cnt;

	always_comb begin
		if (width_q == '0) begin
			weff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			weff = WW'(MAX_WIDTH);
		end else begin
			weff = WW'(width_q);
		end
		w_m1 = weff - WW'(1);
		heff = (height_q == '0) ? 16'd1 : height_q;
		h_m1 = heff - 16'd1;

		accept   = s_tvalid && s_tready;
		col_wrap = (WW'(col_q) == w_m1);
		last     = active_q && (nrow_q == h_m1) && (WW'(ncol_q) == w_m1);

		if (col_q == '0) begin
			clo = (weff >= WW'(2)) ? 2'd1 : 2'd2;
		end else begin
			clo = (WW'(col_q) >= WW'(2)) ? 2'd0 : 2'd1;
		end
		rlo = (nrow_q != '0) ? 2'd0 : 2'd1;
		rhi = (nrow_q < h_m1) ? 2'd2 : 2'd1;
		cnt = CNT_W'(2'd3 - clo) * CNT_W'(rhi - rlo + 2'd1);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign rd_addr  = col_q;
	assign wr_en    = (state_q == ST_SUM);
	assign wr_addr  = hold_q;

	always_comb begin
		cmd          = '0;
		cmd.ld_pix   = accept;
		cmd.in_frame = (krow_q < {1'b0, heff});
		cmd.shift    = (state_q == ST_SUM);
		cmd.col0     = col0_q;
		cmd.mask     = mask_q;
		cmd.count    = cnt_q;
		cmd.recip    = recip_q;
		cmd.load     = (state_q == ST_MUL) && prod_q && !stat.out_busy;
		cmd.last     = last_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q     <= col_q;
			col0_q     <= (col_q == '0);
			mask_q     <= cell_mask(clo, rlo, rhi);
			cnt_q      <= cnt;
			recip_q    <= recip_of(cnt);
			last_q     <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= 11'd1024;
			height_q <= 16'd768;
			col_q    <= '0;
			ncol_q   <= '0;
			pre_q    <= '0;
			active_q <= 1'b0;
			nrow_q   <= '0;
			krow_q   <= '0;
			prod_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SUM;
						prod_q  <= active_q;
					end
				end
				ST_SUM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (!prod_q || !stat.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_wr) begin
				if (cfg_addr == REG_WIDTH) begin
					width_q <= cfg_data[10:0];
				end else begin
					height_q <= cfg_data;
				end
			end

			if (cfg_wr || (accept && last)) begin
				col_q    <= '0;
				ncol_q   <= '0;
				pre_q    <= '0;
				active_q <= 1'b0;
				nrow_q   <= '0;
				krow_q   <= '0;
			end else if (accept) begin
				if (col_wrap) begin
					col_q  <= '0;
					krow_q <= krow_q + 17'd1;
				end else begin
					col_q <= col_q + AW'(1);
				end
				if (!active_q) begin
					if (pre_q == weff) begin
						active_q <= 1'b1;
					end else begin
						pre_q <= pre_q + WW'(1);
					end
				end else if (WW'(ncol_q) == w_m1) begin
					ncol_q <= '0;
					nrow_q <= nrow_q + 16'd1;
				end else begin
					ncol_q <= ncol_q + AW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

[rtl/bbe_dp.sv]
`default_nettype none
module bbe_dp import bbe_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [PIX_W-1:0]             s_tdata,
	input  wire bbe_cmd_t                     cmd,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	output      bbe_stat_t                    stat,
	output      logic                         m_tvalid,
	input  wire logic                         m_tready,
	output      logic [PIX_W-1:0]             m_tdata,
	output      logic                         m_tlast
);
	logic [PIX_W-1:0] pix_q, up_rd, mid_rd;
	logic [PIX_W-1:0] win_q [9];
	logic [PIX_W-1:0] shifted [9];
	logic [PIX_W-1:0] view [9];
	logic [SUM_W-1:0] sum [3];
	logic [SUM_W-1:0] sum_q [3];
	logic [PIX_W-1:0] mean;
	logic             valid_q;

	bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(mid_rd),
		.re(cmd.ld_pix), .raddr(rd_addr), .rdata(up_rd)
	);

	bbe_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(pix_q),
		.re(cmd.ld_pix), .raddr(rd_addr), .rdata(mid_rd)
	);

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			shifted[i] = win_q[i+3];
		end
		shifted[6] = up_rd;
		shifted[7] = mid_rd;
		shifted[8] = pix_q;
		for (int i = 0; i < 9; i++) begin
			view[i] = cmd.col0 ? win_q[i] : shifted[i];
		end
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int i = 0; i < 9; i++) begin
				if (cmd.mask[i]) begin
					sum[ch] = sum[ch] + SUM_W'(view[i][ch*CH_W +: CH_W]);
				end
			end
		end
	end

	// floor((2*sum + count) / (2*count)) by reciprocal multiply
	always_comb begin
		logic [SUM_W:0]    x;
		logic [PROD_W-1:0] p;
		mean = '0;
		for (int ch = 0; ch < 3; ch++) begin
			x = {sum_q[ch], 1'b0} + (SUM_W+1)'(cmd.count);
			p = PROD_W'(x) * PROD_W'(cmd.recip);
			mean[ch*CH_W +: CH_W] = p[RECIP_W +: CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_pix) begin
			pix_q <= cmd.in_frame ? s_tdata : '0;
		end
		if (cmd.shift) begin
			sum_q <= sum;
		end
		if (cmd.load) begin
			m_tdata <= mean;
			m_tlast <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
			valid_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				win_q <= shifted;
			end
			if (cmd.load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid      = valid_q;
	assign stat.out_busy = valid_q && !m_tready;
endmodule
`default_nettype wire

[rtl/box_blur_3x3_edge_average_top.sv]
// 3x3 box blur of an rgb stream, neighbourhood clipped to the frame
// s_ channel: one pixel per beat in raster order; after the frame, width+1 more
// beats drain the pipeline (their data is ignored, as is tuser)
// m_ channel: one blurred pixel per beat, tlast on the last pixel of the frame;
// the result for pixel n is produced by input beat n+width+1
// cfg port: index 0 image width (1..MAX_WIDTH), index 1 image height; a write
// restarts the frame and must happen while the block is idle
// each input beat goes through the line store read, then the window shift and channel sums,
// then the reciprocal multiply into the output register; s_tready is high only
// in the idle state, so a new beat is taken only once the last one has finished
// a producing beat reaches m_tvalid once its multiply step loads the output register
// if m_tready is low while the output register is full, the block holds in its
// last step until the register frees; a new input beat may still be taken while
// a finished result waits, as long as the pending one is not overwritten
// reset clears the window, counters and output valid, and loads width 1024 and
// height 768; line store contents are left as they are
`default_nettype none
module box_blur_3x3_edge_average_top import bbe_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [23:0]           s_tdata,   // red_in, green_in, blue_in
	input  wire logic [0:0]            s_tuser,   // kind
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [23:0]           m_tdata,   // red_out, green_out, blue_out
	output      logic                  m_tlast,
	input  wire logic                  cfg_wr,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_WIDTH);

	bbe_cmd_t      cmd;
	bbe_stat_t     stat;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;

	bbe_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.stat(stat), .cmd(cmd), .rd_addr(rd_addr), .wr_en(wr_en), .wr_addr(wr_addr)
	);

	bbe_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .s_tdata(s_tdata), .cmd(cmd),
		.rd_addr(rd_addr), .wr_en(wr_en), .wr_addr(wr_addr), .stat(stat),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);
endmodule
`default_nettype wire

[rtl/bbe_checker.sv]
`default_nettype none
module bbe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tlast
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// an accepted beat keeps the block busy for its sum and multiply steps
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input taken while busy");

	// no result appears in the cycle right after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result too early");
endmodule

bind box_blur_3x3_edge_average_top bbe_checker u_bbe_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
